// ----- rtl/core/rkrx_pkg.sv -----
// ----------------------------------------------------------------------------
// rkrx_pkg
// Shared types, constants and byte rotate helpers for the repeating key
// rotate/XOR cipher.
// ----------------------------------------------------------------------------
package rkrx_pkg;

    localparam int unsigned MAX_KEY_BYTES = 8;
    localparam int unsigned KEY_POS_W     = $clog2(MAX_KEY_BYTES);
    localparam int unsigned KEY_LEN_W     = 4;
    localparam int unsigned KEY_W         = 8 * MAX_KEY_BYTES;

    // Configuration register indexes
    localparam logic [1:0] CFG_METHOD  = 2'd0;
    localparam logic [1:0] CFG_DECRYPT = 2'd1;
    localparam logic [1:0] CFG_KEY     = 2'd2;
    localparam logic [1:0] CFG_KEY_LEN = 2'd3;

    typedef enum logic [2:0] {
        METH_UNSET     = 3'd0,
        METH_NAIVE     = 3'd1,
        METH_USUAL     = 3'd2,
        METH_SINGLE    = 3'd3,
        METH_ALTERNATE = 3'd4,
        METH_TWIN      = 3'd5,
        METH_BOTH      = 3'd6
    } method_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_METHOD = 2'd1,
        STAT_NO_KEY    = 2'd2
    } status_t;

    // Key byte and status for one item, from the key selector to stage one
    typedef struct packed {
        logic [7:0] key;
        status_t    status;
    } key_ctl_t;

    // Rotation amount of a byte read as a signed char: negative gives zero
    function automatic logic [2:0] rot_amt(input logic [7:0] k);
        rot_amt = k[7] ? 3'd0 : k[2:0];
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w     = {v, v} << n;
        rotl8 = w[15:8];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w     = {v, v} >> n;
        rotr8 = w[7:0];
    endfunction

endpackage

// ----- rtl/core/rkrx_keysel.sv -----
// ----------------------------------------------------------------------------
// rkrx_keysel
// Key position counter and key byte selection, with the error status check.
// ----------------------------------------------------------------------------
module rkrx_keysel
    import rkrx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 last,
    input  logic [2:0]           method_select,
    input  logic [KEY_W-1:0]     key_bytes,
    input  logic [KEY_LEN_W-1:0] key_length,
    output key_ctl_t             ctl
);

    logic [KEY_POS_W-1:0] key_position_reg;
    logic [KEY_POS_W-1:0] key_position_next;
    logic [KEY_LEN_W-1:0] len;
    logic [KEY_POS_W-1:0] pos_use;
    logic [KEY_LEN_W-1:0] pos_inc;
    status_t              status;

    always_comb
    begin
        len = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES)
                                                        : key_length;
        if (method_select == METH_UNSET || method_select > METH_BOTH)
            status = STAT_NO_METHOD;
        else if (len == '0)
            status = STAT_NO_KEY;
        else
            status = STAT_OK;

        // fall back to the first key byte when the key was shortened mid message
        pos_use = ({1'b0, key_position_reg} < len) ? key_position_reg : '0;
        pos_inc = {1'b0, pos_use} + KEY_LEN_W'(1);

        key_position_next = key_position_reg;
        if (status == STAT_OK)
            key_position_next = (pos_inc >= len) ? '0 : pos_inc[KEY_POS_W-1:0];
        if (last)
            key_position_next = '0;

        ctl.key    = key_bytes[{pos_use, 3'b000} +: 8];
        ctl.status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_position_reg <= '0;
        else if (advance)
            key_position_reg <= key_position_next;
    end

endmodule

// ----- rtl/core/rkrx_xform.sv -----
// ----------------------------------------------------------------------------
// rkrx_xform
// Byte transform: XOR with the key byte combined with 8-bit rotations.
// ----------------------------------------------------------------------------
module rkrx_xform
    import rkrx_pkg::*;
(
    input  logic [2:0] method_select,
    input  logic       decrypt_mode,
    input  logic [7:0] text,
    input  key_ctl_t   ctl,
    output logic [7:0] result
);

    logic [7:0] k;
    logic [2:0] a;
    logic [7:0] k_rot;
    logic [2:0] a_rot;
    logic [7:0] xf;

    always_comb
    begin
        k     = ctl.key;
        a     = rot_amt(k);
        k_rot = rotr8(k, a);
        a_rot = rot_amt(k_rot);
        case (method_select)
            METH_NAIVE:
                xf = text ^ k;
            METH_USUAL:
                xf = decrypt_mode ? (rotl8(text, a) ^ k) : rotr8(text ^ k, a);
            METH_SINGLE:
                xf = decrypt_mode ? rotl8(text ^ k, a) : (rotr8(text, a) ^ k);
            METH_ALTERNATE:
                if (k[0])
                    xf = decrypt_mode ? (rotr8(text, a) ^ k) : rotl8(text ^ k, a);
                else
                    xf = decrypt_mode ? (rotl8(text, a) ^ k) : rotr8(text ^ k, a);
            METH_TWIN:
                xf = text ^ k_rot;
            default:
                xf = decrypt_mode ? rotr8(text ^ k, a_rot) : (rotl8(text, a_rot) ^ k);
        endcase
        // force zero on any error status
        result = (ctl.status == STAT_OK) ? xf : 8'h00;
    end

endmodule

// ----- rtl/core/repeating_key_rotate_xor_cipher.sv -----
// ----------------------------------------------------------------------------
// repeating_key_rotate_xor_cipher
// Repeating key rotate/XOR byte cipher with selectable method and direction.
// ----------------------------------------------------------------------------
// An input transfer goes through the input register and the output register to
// the master side. Throughput: one byte per cycle unless the output stalls;
// each register holds one item; a stalled output still lets one more byte in.
// Reset: clears the configuration registers, the key position and both
// valid flags; no clearing pass.
module repeating_key_rotate_xor_cipher
    import rkrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] result_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    logic [2:0]           method_select_reg;
    logic                 decrypt_mode_reg;
    logic [KEY_W-1:0]     key_bytes_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [7:0]           s1_text_reg;
    logic                 s1_last_reg;
    key_ctl_t             s1_ctl_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    status_t              out_status_reg;

    logic                 out_advance;
    logic                 s1_advance;
    logic                 in_xfer;
    key_ctl_t             key_ctl;
    logic [7:0]           xf_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_select_reg <= '0;
            decrypt_mode_reg  <= 1'b0;
            key_bytes_reg     <= '0;
            key_length_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_METHOD:  method_select_reg <= cfg_data[2:0];
                CFG_DECRYPT: decrypt_mode_reg  <= cfg_data[0];
                CFG_KEY:     key_bytes_reg     <= cfg_data;
                CFG_KEY_LEN: key_length_reg    <= cfg_data[KEY_LEN_W-1:0];
            endcase
        end
    end

    // advance each stage when the one after it can take its item
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s1_advance    = !s1_valid_reg || out_advance;
    assign s_axis_tready = s1_advance;
    assign in_xfer       = s_axis_tvalid && s1_advance;

    always_comb
    begin
        s1_valid_next  = s1_advance ? in_xfer : s1_valid_reg;
        out_valid_next = out_advance ? s1_valid_reg : out_valid_reg;
    end

    rkrx_keysel u_keysel (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_xfer),
        .last          (s_axis_tlast),
        .method_select (method_select_reg),
        .key_bytes     (key_bytes_reg),
        .key_length    (key_length_reg),
        .ctl           (key_ctl)
    );

    rkrx_xform u_xform (
        .method_select (method_select_reg),
        .decrypt_mode  (decrypt_mode_reg),
        .text          (s1_text_reg),
        .ctl           (s1_ctl_reg),
        .result        (xf_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_text_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
            s1_ctl_reg  <= key_ctl;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_byte_reg   <= xf_byte;
            out_last_reg   <= s1_last_reg;
            out_status_reg <= s1_ctl_reg.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// ----- rtl/core/rkrx_checker.sv -----
// ----------------------------------------------------------------------------
// rkrx_checker
// Port level checks for the repeating key rotate/XOR cipher.
// ----------------------------------------------------------------------------
module rkrx_checker
    import rkrx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [63:0] cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // hold a stalled result and its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result transfer changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == 8'h00)
        else $error("error status with nonzero result byte");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

    // an empty output register means the input side cannot be blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind repeating_key_rotate_xor_cipher rkrx_checker u_rkrx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
